// File: sv/i2c_rtc_register_access_master_top_defines.svh
// assertion macros for the i2c rtc register access master checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef I2C_RTC_REGISTER_ACCESS_MASTER_TOP_DEFINES_SVH
`define I2C_RTC_REGISTER_ACCESS_MASTER_TOP_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define IRRAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// overlapping implication outside reset
`define IRRAM_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

// next-cycle implication outside reset
`define IRRAM_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// File: sv/irram_pkg.sv
// types and constants of the i2c rtc register access master
// no dependencies
package irram_pkg;

  localparam logic [6:0] DevAddrReset = 7'd104;
  localparam logic [3:0] BitSlotLast  = 4'd9;
  localparam logic [3:0] BitDataEnd   = 4'd8;
  localparam logic [6:0] BcdClamp     = 7'd99;

  // input word, fields in listed order from the msb down
  typedef struct packed {
    logic       kind;
    logic       is_read;
    logic [7:0] reg_addr;
    logic [7:0] write_value;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic       ack_missing;
  } out_item_t;

  // classified word handed from front to back
  typedef struct packed {
    logic       is_req;
    logic       is_read;
    logic [7:0] reg_addr;
    logic [7:0] bcd_value;
    logic       sda;
  } cmd_t;

  typedef enum logic [9:0] {
    StIdle    = 10'b00_0000_0001,
    StStartA  = 10'b00_0000_0010,
    StAddrW   = 10'b00_0000_0100,
    StReg     = 10'b00_0000_1000,
    StData    = 10'b00_0001_0000,
    StStopMid = 10'b00_0010_0000,
    StStartB  = 10'b00_0100_0000,
    StAddrR   = 10'b00_1000_0000,
    StRead    = 10'b01_0000_0000,
    StStopEnd = 10'b10_0000_0000
  } step_e;

endpackage

// File: sv/irram_fifo.sv
// small register queue used between front, back and the result ports
// depends on nothing; Depth must be at least two
module irram_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: sv/irram_front.sv
// front end: classifies an input word and converts the write value to bcd
// depends on irram_pkg
module irram_front (
  input  irram_pkg::in_item_t item_i,
  output irram_pkg::cmd_t     cmd_o
);
  import irram_pkg::*;

  logic [6:0]  clamped;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [3:0]  ones;

  // values above 99 clamp, then divide by ten through 205/2048
  assign clamped  = (item_i.write_value > 8'(BcdClamp)) ? BcdClamp : item_i.write_value[6:0];
  assign prod     = 15'(clamped) * 15'd205;
  assign tens     = prod[14:11];
  assign tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
  assign ones     = 4'(clamped - tens_x10);

  assign cmd_o.is_req    = item_i.kind;
  assign cmd_o.is_read   = item_i.is_read;
  assign cmd_o.reg_addr  = item_i.reg_addr;
  assign cmd_o.bcd_value = {tens, ones};
  assign cmd_o.sda       = item_i.sda_in;

endmodule

// File: sv/irram_back.sv
// back end: bus sequencer, one half-bit phase per word taken from the queue
// depends on irram_pkg
module irram_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [6:0]           dev_addr_i,
  input  logic                 cmd_valid_i,
  input  irram_pkg::cmd_t      cmd_i,
  output logic                 cmd_pop_o,
  input  logic                 res_full_i,
  output logic                 res_push_o,
  output irram_pkg::out_item_t res_o
);
  import irram_pkg::*;

  step_e      step_q, step_d, next_step;
  logic [3:0] bit_q, bit_d, k;
  logic       half_q, half_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] held_reg_q, held_reg_d;
  logic [7:0] held_val_q, held_val_d;
  logic       read_mode_q, read_mode_d;
  logic       nack_q, nack_d;
  logic [7:0] last_read_q, last_read_d;
  logic       scl_q, scl_d, low_q, low_d;
  logic       do_enter, done, rd, advance;

  function automatic logic [7:0] decode_reg(logic [7:0] rg, logic [7:0] b);
    logic [3:0] mask;
    logic [3:0] hi;
    logic       raw;
    mask = 4'hf;
    raw  = 1'b0;
    unique case (rg)
      8'd0, 8'd1: mask = 4'h7;
      8'd2, 8'd4: mask = 4'h3;
      8'd5:       mask = 4'h1;
      8'd6:       mask = 4'hf;
      default:    raw  = 1'b1;
    endcase
    hi = b[7:4] & mask;
    return raw ? b : ({1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'h0, b[3:0]});
  endfunction

  assign advance    = cmd_valid_i && !res_full_i;
  assign cmd_pop_o  = advance;
  assign res_push_o = advance;
  assign rd         = (step_q == StRead);
  assign k          = (bit_q > BitSlotLast) ? BitSlotLast : bit_q;

  always_comb begin
    step_d      = step_q;
    bit_d       = bit_q;
    half_d      = half_q;
    shift_d     = shift_q;
    held_reg_d  = held_reg_q;
    held_val_d  = held_val_q;
    read_mode_d = read_mode_q;
    nack_d      = nack_q;
    last_read_d = last_read_q;
    scl_d       = scl_q;
    low_d       = low_q;
    do_enter    = 1'b0;
    next_step   = StIdle;
    done        = 1'b0;
    if (cmd_i.is_req) begin
      // requests while busy are dropped
      if (step_q == StIdle) begin
        held_reg_d  = cmd_i.reg_addr;
        held_val_d  = cmd_i.bcd_value;
        read_mode_d = cmd_i.is_read;
        nack_d      = 1'b0;
        do_enter    = 1'b1;
        next_step   = StStartA;
      end
    end else begin
      unique case (step_q)
        StIdle: begin
        end
        StStartA, StStartB: begin
          scl_d = 1'b1;
          if (bit_q == 4'd0) begin
            low_d = 1'b0;
            bit_d = 4'd1;
          end else begin
            low_d     = 1'b1;
            do_enter  = 1'b1;
            next_step = (step_q == StStartA) ? StAddrW : StAddrR;
          end
        end
        StAddrW, StReg, StData, StAddrR, StRead: begin
          if (k == BitSlotLast) begin
            // ack slot done: sample ack or store the decoded byte
            if (rd) begin
              last_read_d = decode_reg(held_reg_q, shift_q);
            end else if (cmd_i.sda) begin
              nack_d = 1'b1;
            end
            scl_d    = 1'b0;
            low_d    = 1'b0;
            do_enter = 1'b1;
            unique case (step_q)
              StAddrW: next_step = StReg;
              StReg:   next_step = read_mode_q ? StStopMid : StData;
              StAddrR: next_step = StRead;
              default: next_step = StStopEnd;
            endcase
          end else if (!half_q) begin
            if (rd && k != 4'd0) begin
              shift_d = {shift_q[6:0], cmd_i.sda};
            end
            scl_d = 1'b0;
            if (!rd && k < BitDataEnd) begin
              low_d   = ~shift_q[7];
              shift_d = {shift_q[6:0], 1'b0};
            end else begin
              low_d = 1'b0;
            end
            half_d = 1'b1;
          end else begin
            scl_d  = 1'b1;
            half_d = 1'b0;
            bit_d  = k + 4'd1;
          end
        end
        StStopMid, StStopEnd: begin
          if (bit_q == 4'd0) begin
            scl_d = 1'b0;
            low_d = 1'b1;
            bit_d = 4'd1;
          end else if (bit_q == 4'd1) begin
            scl_d = 1'b1;
            low_d = 1'b1;
            bit_d = 4'd2;
          end else begin
            scl_d     = 1'b1;
            low_d     = 1'b0;
            do_enter  = 1'b1;
            next_step = (step_q == StStopMid) ? StStartB : StIdle;
            done      = (step_q == StStopEnd);
          end
        end
        default: begin
          do_enter  = 1'b1;
          next_step = StIdle;
          scl_d     = 1'b1;
          low_d     = 1'b0;
        end
      endcase
    end
    if (do_enter) begin
      step_d = next_step;
      bit_d  = 4'd0;
      half_d = 1'b0;
      unique case (next_step)
        StAddrW: shift_d = {dev_addr_i, 1'b0};
        StAddrR: shift_d = {dev_addr_i, 1'b1};
        StReg:   shift_d = held_reg_q;
        StData:  shift_d = held_val_q;
        StRead:  shift_d = 8'h00;
        default: begin
        end
      endcase
    end
  end

  assign res_o.scl          = scl_d;
  assign res_o.sda_pull_low = low_d;
  assign res_o.busy_res     = (step_d != StIdle);
  assign res_o.done_res     = done;
  assign res_o.read_value   = last_read_d;
  assign res_o.ack_missing  = nack_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StIdle;
      bit_q       <= '0;
      half_q      <= 1'b0;
      shift_q     <= '0;
      held_reg_q  <= '0;
      held_val_q  <= '0;
      read_mode_q <= 1'b0;
      nack_q      <= 1'b0;
      last_read_q <= '0;
      scl_q       <= 1'b1;
      low_q       <= 1'b0;
    end else if (advance) begin
      step_q      <= step_d;
      bit_q       <= bit_d;
      half_q      <= half_d;
      shift_q     <= shift_d;
      held_reg_q  <= held_reg_d;
      held_val_q  <= held_val_d;
      read_mode_q <= read_mode_d;
      nack_q      <= nack_d;
      last_read_q <= last_read_d;
      scl_q       <= scl_d;
      low_q       <= low_d;
    end
  end

endmodule

// File: sv/i2c_rtc_register_access_master_top.sv
// i2c rtc register access master: one result word per accepted input word
// a result is poppable once its word has passed the command queue, the sequencer and the result queue
// throughput: one word per cycle while the result queue is not full; the sequencer takes one step per word
// the command and result queues decouple front, sequencer and consumer
// reset: sequencer idle, lines released, both queues empty, address 104
// depends on irram_pkg, irram_fifo, irram_front, irram_back
module i2c_rtc_register_access_master_top #(
  parameter int unsigned CmdDepth = 2,
  parameter int unsigned ResDepth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  irram_pkg::in_item_t  in_item_i,
  output logic                 empty,
  input  logic                 pop,
  output irram_pkg::out_item_t out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [6:0]           cfg_data_i
);
  import irram_pkg::*;

  logic [6:0] dev_addr_q;
  cmd_t       front_cmd, queued_cmd;
  logic       cmd_empty, cmd_pop;
  out_item_t  back_res;
  logic       res_push, res_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DevAddrReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dev_addr_q <= cfg_data_i;
    end
  end

  irram_front u_front (
    .item_i (in_item_i),
    .cmd_o  (front_cmd)
  );

  irram_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .rdata_o (queued_cmd),
    .empty_o (cmd_empty)
  );

  irram_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dev_addr_i  (dev_addr_q),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (queued_cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  irram_fifo #(
    .Width ($bits(out_item_t)),
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_item_o),
    .empty_o (empty)
  );

endmodule

// File: sv/irram_checker.sv
// port-level checker for the i2c rtc register access master, bound to the top
// depends on irram_pkg and i2c_rtc_register_access_master_top_defines.svh
`include "i2c_rtc_register_access_master_top_defines.svh"

module irram_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 empty,
  input logic                 pop,
  input irram_pkg::out_item_t out_item_o,
  input logic                 cfg_ready_o
);
  import irram_pkg::*;

  // a waiting word holds until it is popped
  `IRRAM_ASSERT_NXT(a_res_hold, !empty && !pop, !empty && $stable(out_item_o), "result word changed while waiting")
  // the final stop leaves the sequencer idle
  `IRRAM_ASSERT_IMP(a_done_idle, !empty && out_item_o.done_res, !out_item_o.busy_res, "done while still busy")
  // when idle both lines are released
  `IRRAM_ASSERT_IMP(a_idle_lines, !empty && !out_item_o.busy_res, out_item_o.scl && !out_item_o.sda_pull_low, "bus not released in idle")
  `IRRAM_ASSERT(a_cfg_ready, cfg_ready_o, "config channel not ready")

endmodule

bind i2c_rtc_register_access_master_top irram_checker u_checker (.*);
